@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the vibration pattern sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define VPS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define VPS_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define VPS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/vps_pkg.sv @@
// Shared types, codes and helpers of the vibration pattern sequencer.
`default_nettype none

package vps_pkg;

	localparam int PATTERN_DEPTH_DEF = 8;
	localparam int ENTRY_DEPTH_DEF   = 256;

	localparam int DUR_W  = 15;  // stored interval, clamped to 0..32767
	localparam int IN_W   = 16;  // signed duration fields of a request
	localparam int REP_W  = 8;
	localparam int REQ_W  = 2;
	localparam int ST_W   = 2;
	localparam int WAIT_W = 4;

	// Request types
	localparam logic [REQ_W-1:0] REQ_ENTRY = 2'd0;
	localparam logic [REQ_W-1:0] REQ_PULSE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_TICK  = 2'd2;

	// Status codes
	localparam logic [ST_W-1:0] ST_OK      = 2'd0;
	localparam logic [ST_W-1:0] ST_QFULL   = 2'd1;
	localparam logic [ST_W-1:0] ST_NOSPACE = 2'd2;

	typedef struct packed {
		logic [REQ_W-1:0]       req_type;
		logic signed [IN_W-1:0] duration;
		logic                   last_entry;
		logic signed [IN_W-1:0] on_time;
		logic signed [IN_W-1:0] off_time;
		logic [REP_W-1:0]       repeat_count;
	} vps_req_t;

	typedef struct packed {
		logic [ST_W-1:0]   status;
		logic              motor_pin;
		logic              busy_res;
		logic [WAIT_W-1:0] patterns_waiting;
	} vps_res_t;

	// Negative durations become zero
	function automatic logic [DUR_W-1:0] clamp_dur(input logic signed [IN_W-1:0] v);
		return v[IN_W-1] ? '0 : v[DUR_W-1:0];
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/vps_entry_ram.sv @@
// Entry store: one write port, one read port with registered read data.
`default_nettype none

module vps_entry_ram
	import vps_pkg::*;
#(
	parameter int DEPTH = ENTRY_DEPTH_DEF,
	parameter int DW    = DUR_W,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ hw/rtl/vibration_pattern_sequencer.sv @@
// Top level of the vibration pattern sequencer: request sequencer, pattern queue, playback.
//
//  channel   | signals                 | handshake
//  ----------+-------------------------+---------------------------------------
//  request   | start, busy, req        | taken at an edge with start & !busy
//  result    | done, res               | one cycle strobe, cannot be held off
//  config    | cfg_we, cfg_wdata       | written at an edge with cfg_we high
//
// A transaction passes through exec, then settle, which alternates with pop and consume
// while playback settles; a pulse first writes its stored entries (2 x repeat, a zero
// repeat counting as one) in the fill state. The entry RAM has one write and one registered
// read port, so fills run one entry per cycle and each entry read spans settle and consume.
// Reset is asynchronous and clears all control state; entry and queue memories are
// not cleared. The result cannot be stalled; busy stays high until the result strobe.
`default_nettype none

`include "assert_macros.svh"

module vibration_pattern_sequencer
	import vps_pkg::*;
#(
	parameter int PATTERN_DEPTH = PATTERN_DEPTH_DEF,
	parameter int ENTRY_DEPTH   = ENTRY_DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  vps_req_t req,
	output logic     busy,
	output logic     done,
	output vps_res_t res,
	input  logic     cfg_we,
	input  logic     cfg_wdata
);

	localparam int EA = $clog2(ENTRY_DEPTH);
	localparam int LW = $clog2(ENTRY_DEPTH + 1);
	localparam int QA = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
	localparam int QC = $clog2(PATTERN_DEPTH + 1);
	localparam int SW = ((LW > REP_W + 1) ? LW : REP_W + 1) + 1;

	localparam logic [EA-1:0] ADDR_LAST = EA'(ENTRY_DEPTH - 1);
	localparam logic [QA-1:0] QPTR_LAST = QA'(PATTERN_DEPTH - 1);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_EXEC    = 3'd1;
	localparam logic [2:0] S_FILL    = 3'd2;
	localparam logic [2:0] S_SETTLE  = 3'd3;
	localparam logic [2:0] S_POP     = 3'd4;
	localparam logic [2:0] S_CONSUME = 3'd5;

	typedef struct packed {
		logic [EA-1:0] start;
		logic [LW-1:0] len;
	} qent_t;

	function automatic logic [EA-1:0] wrap_sum(input logic [EA-1:0] a, input logic [LW-1:0] b);
		logic [LW:0] s;
		s = (LW+1)'(a) + (LW+1)'(b);
		if (s >= (LW+1)'(ENTRY_DEPTH)) begin
			s = s - (LW+1)'(ENTRY_DEPTH);
		end
		return s[EA-1:0];
	endfunction

	function automatic logic [EA-1:0] addr_inc(input logic [EA-1:0] a);
		return (a == ADDR_LAST) ? '0 : a + 1'b1;
	endfunction

	function automatic logic [QA-1:0] qptr_inc(input logic [QA-1:0] p);
		return (p == QPTR_LAST) ? '0 : p + 1'b1;
	endfunction

	logic [2:0]       state_q;
	vps_req_t         req_q;
	logic [ST_W-1:0]  status_q;
	logic             active_high_q;
	logic [QA-1:0]    q_head_q;
	logic [QA-1:0]    q_tail_q;
	logic [QC-1:0]    q_count_q;
	logic [EA-1:0]    alloc_q;
	logic [LW-1:0]    used_q;
	logic [LW-1:0]    build_q;
	logic [EA-1:0]    play_addr_q;
	logic [LW-1:0]    play_left_q;
	logic [DUR_W-1:0] interval_q;
	logic             phase_on_q;
	logic             playing_q;
	logic [EA-1:0]    fill_addr_q;
	logic [LW-1:0]    fill_left_q;
	logic             fill_odd_q;
	logic [LW-1:0]    pulse_len_q;
	logic             done_q;
	vps_res_t         res_q;
	qent_t            q_rd_q;
	qent_t            queue_mem [PATTERN_DEPTH];

	logic [DUR_W-1:0] dur_c;
	logic [DUR_W-1:0] on_c;
	logic [DUR_W-1:0] off_c;
	logic [REP_W-1:0] rep_c;
	logic [REP_W:0]   pulse_n_c;
	logic             no_room_entry;
	logic             no_room_pulse;
	logic             q_full;
	logic [LW-1:0]    build_next;
	logic             commit_go;
	logic [LW-1:0]    commit_len;
	logic             finish;
	logic             motor;
	logic             ram_we;
	logic [EA-1:0]    ram_waddr;
	logic [DUR_W-1:0] ram_wdata;
	logic [DUR_W-1:0] ram_rdata;

	// Request decode and space checks
	always_comb begin
		dur_c         = clamp_dur(req_q.duration);
		on_c          = clamp_dur(req_q.on_time);
		off_c         = clamp_dur(req_q.off_time);
		rep_c         = (req_q.repeat_count == '0) ? REP_W'(1) : req_q.repeat_count;
		pulse_n_c     = {rep_c, 1'b0};
		no_room_entry = ((LW+1)'(used_q) + (LW+1)'(build_q)) >= (LW+1)'(ENTRY_DEPTH);
		no_room_pulse = (SW'(used_q) + SW'(pulse_n_c)) > SW'(ENTRY_DEPTH);
		q_full        = q_count_q >= QC'(PATTERN_DEPTH);
		build_next    = build_q + 1'b1;
	end

	// Entry RAM write port and commit of a finished pattern
	always_comb begin
		ram_we     = 1'b0;
		ram_waddr  = wrap_sum(alloc_q, build_q);
		ram_wdata  = dur_c;
		commit_go  = 1'b0;
		commit_len = build_next;
		if (state_q == S_EXEC && req_q.req_type == REQ_ENTRY && !no_room_entry) begin
			ram_we    = 1'b1;
			commit_go = req_q.last_entry && !q_full;
		end else if (state_q == S_FILL) begin
			ram_we     = 1'b1;
			ram_waddr  = fill_addr_q;
			ram_wdata  = fill_odd_q ? off_c : on_c;
			commit_len = pulse_len_q;
			commit_go  = (fill_left_q == LW'(1));
		end
	end

	// Playback settles when idle with nothing queued or an interval is running
	assign finish = (state_q == S_SETTLE) &&
		((!playing_q && q_count_q == '0) || (playing_q && interval_q != '0));
	assign motor = playing_q && phase_on_q && (interval_q != '0);

	vps_entry_ram #(
		.DEPTH(ENTRY_DEPTH),
		.DW   (DUR_W)
	) u_entry_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(play_addr_q),
		.rdata(ram_rdata)
	);

	// Pattern queue memory
	always_ff @(posedge clk) begin
		if (commit_go) begin
			queue_mem[q_tail_q] <= '{start: alloc_q, len: commit_len};
		end
		q_rd_q <= queue_mem[q_head_q];
	end

	// Request capture and result register
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			req_q <= req;
		end
		if (finish) begin
			res_q.status           <= status_q;
			res_q.motor_pin        <= active_high_q ? motor : !motor;
			res_q.busy_res         <= playing_q;
			res_q.patterns_waiting <= WAIT_W'(q_count_q);
		end
	end

	// Main sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			status_q      <= ST_OK;
			active_high_q <= 1'b1;
			q_head_q      <= '0;
			q_tail_q      <= '0;
			q_count_q     <= '0;
			alloc_q       <= '0;
			used_q        <= '0;
			build_q       <= '0;
			play_addr_q   <= '0;
			play_left_q   <= '0;
			interval_q    <= '0;
			phase_on_q    <= 1'b0;
			playing_q     <= 1'b0;
			fill_addr_q   <= '0;
			fill_left_q   <= '0;
			fill_odd_q    <= 1'b0;
			pulse_len_q   <= '0;
			done_q        <= 1'b0;
		end else begin
			done_q <= finish;
			if (cfg_we) begin
				active_high_q <= cfg_wdata;
			end

			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_EXEC;
					end
				end

				S_EXEC: begin
					case (req_q.req_type)
						REQ_ENTRY: begin
							state_q <= S_SETTLE;
							if (no_room_entry) begin
								build_q  <= '0;
								status_q <= ST_NOSPACE;
							end else if (req_q.last_entry) begin
								build_q  <= '0;
								status_q <= q_full ? ST_QFULL : ST_OK;
							end else begin
								build_q  <= build_next;
								status_q <= ST_OK;
							end
						end
						REQ_PULSE: begin
							build_q <= '0;
							if (no_room_pulse) begin
								status_q <= ST_NOSPACE;
								state_q  <= S_SETTLE;
							end else if (q_full) begin
								status_q <= ST_QFULL;
								state_q  <= S_SETTLE;
							end else begin
								status_q    <= ST_OK;
								fill_addr_q <= alloc_q;
								fill_left_q <= LW'(pulse_n_c);
								pulse_len_q <= LW'(pulse_n_c);
								fill_odd_q  <= 1'b0;
								state_q     <= S_FILL;
							end
						end
						REQ_TICK: begin
							state_q  <= S_SETTLE;
							status_q <= ST_OK;
							if (playing_q && interval_q != '0) begin
								interval_q <= interval_q - 1'b1;
							end
						end
						default: begin
							state_q  <= S_SETTLE;
							status_q <= ST_OK;
						end
					endcase
				end

				// Pulse expansion: alternate on and off entries, one per cycle
				S_FILL: begin
					fill_addr_q <= addr_inc(fill_addr_q);
					fill_left_q <= fill_left_q - 1'b1;
					fill_odd_q  <= !fill_odd_q;
					if (fill_left_q == LW'(1)) begin
						state_q <= S_SETTLE;
					end
				end

				S_SETTLE: begin
					if (finish) begin
						state_q <= S_IDLE;
					end else if (!playing_q) begin
						state_q <= S_POP;
					end else if (play_left_q == '0) begin
						playing_q  <= 1'b0;
						phase_on_q <= 1'b0;
					end else begin
						state_q <= S_CONSUME;
					end
				end

				// Start the pattern at the queue head
				S_POP: begin
					play_addr_q <= q_rd_q.start;
					play_left_q <= q_rd_q.len;
					q_head_q    <= qptr_inc(q_head_q);
					q_count_q   <= q_count_q - 1'b1;
					playing_q   <= 1'b1;
					phase_on_q  <= 1'b0;
					interval_q  <= '0;
					state_q     <= S_SETTLE;
				end

				// Entry read data is back; zero entries fall through next settle
				S_CONSUME: begin
					phase_on_q  <= !phase_on_q;
					interval_q  <= ram_rdata;
					play_addr_q <= addr_inc(play_addr_q);
					play_left_q <= play_left_q - 1'b1;
					used_q      <= used_q - 1'b1;
					state_q     <= S_SETTLE;
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// Commit to the queue; never in the same cycle as a pop or consume
			if (commit_go) begin
				q_tail_q  <= qptr_inc(q_tail_q);
				q_count_q <= q_count_q + 1'b1;
				alloc_q   <= wrap_sum(alloc_q, commit_len);
				used_q    <= used_q + commit_len;
			end
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign res  = res_q;

	// Checks
	`VPS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
	`VPS_ASSERT_IMPL(a_idle_queue, state_q == S_IDLE && !playing_q, q_count_q == '0, "pattern waits while playback is idle")
	`VPS_ASSERT_IMPL(a_idle_phase, !playing_q && state_q == S_IDLE, !phase_on_q, "phase on without a pattern playing")
	`VPS_ASSERT(a_space, ((LW+1)'(used_q) + (LW+1)'(build_q)) <= (LW+1)'(ENTRY_DEPTH), "entry space overcommitted")

endmodule

`default_nettype wire
